>>> sv/ufra_pkg.sv
// shared types and constants of the udp flow request accumulator
package ufra_pkg;

  localparam int unsigned MAX_FLOWS     = 8;
  localparam int unsigned BUF_BYTES     = 4096;
  localparam int unsigned SUMMARY_BYTES = 8;

  localparam int unsigned FLOW_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int unsigned USED_W = $clog2(MAX_FLOWS + 1);
  localparam int unsigned FILL_W = $clog2(BUF_BYTES + 1);
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned SUM_W  = ((LEN_W > FILL_W) ? LEN_W : FILL_W) + 1;
  localparam int unsigned HEAD_W = (SUMMARY_BYTES > 1) ? $clog2(SUMMARY_BYTES) : 1;
  localparam int unsigned KEY_W  = 48;

  localparam logic [15:0] ETHER_IPV4      = 16'h0800;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [15:0] SERVER_PORT_RST = 16'd8080;
  localparam logic [7:0]  CHAR_Z          = 8'h5A;
  localparam logic [7:0]  CHAR_NL         = 8'h0A;

  typedef struct packed {
    logic             headers_present;
    logic [15:0]      ether_type;
    logic [7:0]       ip_protocol;
    logic [15:0]      dest_port;
    logic [31:0]      src_address;
    logic [15:0]      src_udp_port;
    logic [LEN_W-1:0] payload_len;
    logic [7:0]       data_byte;
    logic             first_beat;
    logic             last_beat;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [63:0] summary;
  } out_item_t;

  typedef enum logic [1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_DROP    = 2'd1,
    VERDICT_ABORT   = 2'd2,
    VERDICT_SUMMARY = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    CLS_PASS  = 2'd0,
    CLS_ABORT = 2'd1,
    CLS_FLOW  = 2'd2
  } cls_e;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_PASS   = 2'd1,
    ST_ABORT  = 2'd2,
    ST_DROP   = 2'd3
  } pkt_st_e;

  typedef struct packed {
    logic              first_beat;
    logic              last_beat;
    cls_e              cls;
    logic [FLOW_W-1:0] flow;
    logic [LEN_W-1:0]  payload_len;
    logic [7:0]        data_byte;
  } beat_t;

endpackage

>>> sv/ufra_front.sv
// front part: header filter, flow table lookup and allocation, beat queue
module ufra_front import ufra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] server_port_i,
  input  logic        push,
  input  in_item_t    in_item_i,
  output logic        full,
  output logic        beat_valid_o,
  output beat_t       beat_o,
  input  logic        beat_pop_i
);

  logic [KEY_W-1:0]  keys_q [MAX_FLOWS];
  logic [USED_W-1:0] used_q;
  logic [KEY_W-1:0]  key;
  logic              filter_hit;
  logic              found;
  logic [FLOW_W-1:0] hit_idx;
  logic              table_full;
  logic              accept;
  logic              alloc;
  beat_t             beat;

  beat_t             q_mem [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              do_pop;

  assign key = {in_item_i.src_address, in_item_i.src_udp_port};
  assign filter_hit = in_item_i.headers_present && (in_item_i.ether_type == ETHER_IPV4) &&
                      (in_item_i.ip_protocol == PROTO_UDP) &&
                      (in_item_i.dest_port == server_port_i);
  assign table_full = (used_q >= USED_W'(MAX_FLOWS));

  // lowest matching slot among the allocated ones
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int f = MAX_FLOWS - 1; f >= 0; f--) begin
      if ((USED_W'(f) < used_q) && (keys_q[f] == key)) begin
        found   = 1'b1;
        hit_idx = FLOW_W'(f);
      end
    end
  end

  always_comb begin
    beat.first_beat  = in_item_i.first_beat;
    beat.last_beat   = in_item_i.last_beat;
    beat.payload_len = in_item_i.payload_len;
    beat.data_byte   = in_item_i.data_byte;
    beat.flow        = hit_idx;
    beat.cls         = CLS_FLOW;
    if (!filter_hit) begin
      beat.cls = CLS_PASS;
    end else if (!found) begin
      if (table_full) begin
        beat.cls = CLS_ABORT;
      end else begin
        beat.flow = used_q[FLOW_W-1:0];
      end
    end
  end

  assign full   = (cnt_q == 2'd2);
  assign accept = push && !full;
  assign alloc  = accept && in_item_i.first_beat && filter_hit && !found && !table_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (alloc) begin
      used_q <= used_q + USED_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc) begin
      keys_q[used_q[FLOW_W-1:0]] <= key;
    end
  end

  // two-entry queue toward the back part
  assign do_pop       = beat_pop_i && beat_valid_o;
  assign beat_valid_o = (cnt_q != 2'd0);
  assign beat_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, accept} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= beat;
    end
  end

endmodule

>>> sv/ufra_back.sv
// back part: per-flow fill, buffer head and tail tracking, verdicts, result queue
module ufra_back import ufra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      beat_valid_i,
  input  beat_t     beat_i,
  output logic      beat_pop_o,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item_o
);

  pkt_st_e           st_q, st_e;
  logic [FLOW_W-1:0] flow_q, flow_e;
  logic [LEN_W-1:0]  off_q, off_e, off_n, plan_q, plan_e;
  logic [FILL_W-1:0] fill_q [MAX_FLOWS];
  logic [7:0]        head_q [MAX_FLOWS][SUMMARY_BYTES];
  logic [7:0]        tail_q [MAX_FLOWS];
  logic [7:0]        b0_q, b1_q, b0_n, b1_n;
  logic [7:0]        head_row [SUMMARY_BYTES];
  logic [7:0]        prev_byte;
  logic [FILL_W-1:0] fill_cur, fill_wr;
  logic [SUM_W-1:0]  pos, fill_sum;
  logic              wr, commit;
  verdict_e          verdict;
  logic [63:0]       summary;

  out_item_t         o_mem [2];
  logic              o_wr_q, o_rd_q;
  logic [1:0]        o_cnt_q;
  logic              take, o_push, o_pop;

  assign beat_pop_o = beat_valid_i && (o_cnt_q != 2'd2);
  assign take       = beat_pop_o;
  assign o_push     = take && beat_i.last_beat;

  always_comb begin
    st_e   = st_q;
    flow_e = flow_q;
    off_e  = off_q;
    plan_e = plan_q;
    if (beat_i.first_beat) begin
      off_e  = '0;
      plan_e = beat_i.payload_len;
      unique case (beat_i.cls)
        CLS_PASS:  st_e = ST_PASS;
        CLS_ABORT: st_e = ST_ABORT;
        CLS_FLOW: begin
          flow_e = beat_i.flow;
          if (beat_i.payload_len == '0) begin
            st_e = ST_DROP;
          end else if (SUM_W'(beat_i.payload_len) + SUM_W'(fill_q[beat_i.flow]) >
                       SUM_W'(BUF_BYTES)) begin
            st_e = ST_ABORT;
          end else begin
            st_e = ST_ACCEPT;
          end
        end
        default:   st_e = ST_PASS;
      endcase
    end
  end

  // byte append; only the head bytes and the packet's last two are kept
  always_comb begin
    fill_cur = fill_q[flow_e];
    wr       = (st_e == ST_ACCEPT) && (off_e < plan_e);
    pos      = SUM_W'(fill_cur) + SUM_W'(off_e);
    head_row = head_q[flow_e];
    if (wr && (pos < SUM_W'(SUMMARY_BYTES))) begin
      head_row[pos[HEAD_W-1:0]] = beat_i.data_byte;
    end
    off_n = wr ? off_e + LEN_W'(1) : off_e;
    b1_n  = wr ? beat_i.data_byte : b1_q;
    b0_n  = wr ? b1_q : b0_q;
  end

  always_comb begin
    verdict   = VERDICT_DROP;
    summary   = '0;
    commit    = 1'b0;
    fill_sum  = SUM_W'(fill_cur) + SUM_W'(off_n);
    fill_wr   = (fill_sum > SUM_W'(BUF_BYTES)) ? FILL_W'(BUF_BYTES) : fill_sum[FILL_W-1:0];
    // second to last byte comes from an earlier packet when only one was added
    prev_byte = (off_n >= LEN_W'(2)) ? b0_n : tail_q[flow_e];
    unique case (st_e)
      ST_PASS:  verdict = VERDICT_PASS;
      ST_ABORT: verdict = VERDICT_ABORT;
      ST_DROP:  verdict = VERDICT_DROP;
      ST_ACCEPT: begin
        if (off_n != '0) begin
          commit = 1'b1;
          if ((fill_wr >= FILL_W'(2)) && (prev_byte == CHAR_Z) && (b1_n == CHAR_NL)) begin
            verdict = VERDICT_SUMMARY;
            fill_wr = '0;
            for (int i = 0; i < SUMMARY_BYTES; i++) begin
              summary[8*i +: 8] = head_row[i];
            end
          end
        end
      end
      default:  verdict = VERDICT_DROP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_ACCEPT;
      flow_q <= '0;
      off_q  <= '0;
      plan_q <= '0;
      for (int f = 0; f < MAX_FLOWS; f++) begin
        fill_q[f] <= '0;
        tail_q[f] <= '0;
        for (int i = 0; i < SUMMARY_BYTES; i++) begin
          head_q[f][i] <= '0;
        end
      end
    end else if (take) begin
      flow_q         <= flow_e;
      head_q[flow_e] <= head_row;
      if (beat_i.last_beat) begin
        st_q   <= ST_ACCEPT;
        off_q  <= '0;
        plan_q <= '0;
        if (commit) begin
          fill_q[flow_e] <= fill_wr;
          tail_q[flow_e] <= b1_n;
        end
      end else begin
        st_q   <= st_e;
        off_q  <= off_n;
        plan_q <= plan_e;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      b0_q <= b0_n;
      b1_q <= b1_n;
    end
  end

  // result queue
  assign empty      = (o_cnt_q == 2'd0);
  assign o_pop      = pop && !empty;
  assign out_item_o = o_mem[o_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_wr_q  <= 1'b0;
      o_rd_q  <= 1'b0;
      o_cnt_q <= 2'd0;
    end else begin
      if (o_push) o_wr_q <= !o_wr_q;
      if (o_pop)  o_rd_q <= !o_rd_q;
      o_cnt_q <= o_cnt_q + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      o_mem[o_wr_q].verdict <= verdict;
      o_mem[o_wr_q].summary <= summary;
    end
  end

  a_out_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) o_cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[flow_q] <= FILL_W'(BUF_BYTES))
    else $error("flow fill above buffer size");

  a_summary_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_push && verdict == VERDICT_SUMMARY) |=> fill_q[$past(flow_e)] == '0)
    else $error("summary verdict without fill reset");

endmodule

>>> sv/udp_flow_request_accumulator.sv
// top level of the udp flow request accumulator
// Takes one packet beat per clock while full is low, with no gaps needed: the front part
// classifies a beat and looks up its flow as it is accepted, the back part updates the
// flow's fill and writes the verdict when it takes the beat from the beat queue, and the
// result is then held in the result queue until it is popped. Only the first buffer bytes
// and each flow's last byte decide any result, so those are held in flip-flops cleared by
// reset and no clearing pass is needed; the block takes items right after reset. A
// two-entry beat queue between the parts and a two-entry result queue let either side
// stall without losing throughput.
module udp_flow_request_accumulator import ufra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] server_port_q;
  logic        beat_valid;
  logic        beat_pop;
  beat_t       beat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_port_q <= SERVER_PORT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      server_port_q <= cfg_data_i;
    end
  end

  ufra_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .server_port_i (server_port_q),
    .push          (push),
    .in_item_i     (in_item_i),
    .full          (full),
    .beat_valid_o  (beat_valid),
    .beat_o        (beat),
    .beat_pop_i    (beat_pop)
  );

  ufra_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .beat_pop_o   (beat_pop),
    .pop          (pop),
    .empty        (empty),
    .out_item_o   (out_item_o)
  );

endmodule

>>> test/udp_flow_request_accumulator_test.sv
// testbench for the udp flow request accumulator: directed and random packets checked against a predictor
module udp_flow_request_accumulator_test;
  import ufra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class flow_scoreboard;
    logic [47:0] keys [MAX_FLOWS];
    int unsigned used;
    int unsigned fill [MAX_FLOWS];
    logic [7:0]  store [MAX_FLOWS*BUF_BYTES];
    int unsigned pkt_flow;
    pkt_st_e     status;
    int unsigned offset;
    int unsigned planned;
    logic [15:0] port;
    out_item_t   expected_q [$];
    int unsigned mismatches;
    int unsigned results;
    int unsigned verdict_cnt [4];

    function void clear_state();
      used = 0;
      pkt_flow = 0;
      status = ST_ACCEPT;
      offset = 0;
      planned = 0;
      port = SERVER_PORT_RST;
      foreach (fill[i]) fill[i] = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void start_packet(in_item_t it);
      logic [47:0] key;
      int unsigned f;
      bit found;
      key = {it.src_address, it.src_udp_port};
      found = 0;
      offset = 0;
      planned = 32'(it.payload_len);
      if (!it.headers_present || it.ether_type != ETHER_IPV4 ||
          it.ip_protocol != PROTO_UDP || it.dest_port != port) begin
        status = ST_PASS;
        return;
      end
      for (f = 0; f < used; f++) begin
        if (keys[f] == key) begin
          found = 1;
          break;
        end
      end
      if (!found) begin
        if (used >= MAX_FLOWS) begin
          status = ST_ABORT;
          return;
        end
        f = used;
        keys[f] = key;
        used++;
      end
      pkt_flow = f;
      if (planned == 0) status = ST_DROP;
      else if (planned + fill[f] > BUF_BYTES) status = ST_ABORT;
      else status = ST_ACCEPT;
    endfunction

    function verdict_e close_request(output logic [63:0] summ);
      int unsigned nf, base;
      summ = '0;
      if (offset == 0) return VERDICT_DROP;
      nf = fill[pkt_flow] + offset;
      if (nf > BUF_BYTES) nf = BUF_BYTES;
      fill[pkt_flow] = nf;
      if (nf < 2) return VERDICT_DROP;
      base = pkt_flow * BUF_BYTES;
      if (store[base+nf-2] != CHAR_Z || store[base+nf-1] != CHAR_NL) return VERDICT_DROP;
      for (int i = 0; i < SUMMARY_BYTES; i++) summ[8*i +: 8] = store[base+i];
      fill[pkt_flow] = 0;
      return VERDICT_SUMMARY;
    endfunction

    function void note_beat(in_item_t it);
      out_item_t o;
      logic [63:0] summ;
      int unsigned pos;
      if (it.first_beat) start_packet(it);
      if (status == ST_ACCEPT && offset < planned) begin
        pos = fill[pkt_flow] + offset;
        if (pos < BUF_BYTES) store[pkt_flow*BUF_BYTES + pos] = it.data_byte;
        offset++;
      end
      if (!it.last_beat) return;
      summ = '0;
      case (status)
        ST_PASS:  o.verdict = VERDICT_PASS;
        ST_ABORT: o.verdict = VERDICT_ABORT;
        ST_DROP:  o.verdict = VERDICT_DROP;
        default:  o.verdict = close_request(summ);
      endcase
      o.summary = summ;
      status = ST_ACCEPT;
      offset = 0;
      planned = 0;
      expected_q.push_back(o);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict %0d summary %h", got.verdict, got.summary);
        return;
      end
      want = expected_q.pop_front();
      results++;
      verdict_cnt[want.verdict]++;
      if (got.verdict !== want.verdict || got.summary !== want.summary) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected verdict %0d summary %h, got verdict %0d summary %h",
                   want.verdict, want.summary, got.verdict, got.summary);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop = 0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  flow_scoreboard sb;
  bit          hold_rx = 0;
  int unsigned beats_sent = 0;
  int unsigned packets_sent = 0;
  logic [47:0] key_pool [10];

  udp_flow_request_accumulator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .in_item_i(in_item_i),
    .empty(empty), .pop(pop), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    #3ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_beat(in_item_t it);
    repeat ($urandom_range(0, 12)) begin
      @(negedge clk_i);
      push = 0;
    end
    @(negedge clk_i);
    push = 1;
    in_item_i = it;
    do @(posedge clk_i); while (full);
    sb.note_beat(it);
    beats_sent++;
  endtask

  function automatic in_item_t request_head(logic [47:0] key, int unsigned plen);
    in_item_t h;
    h = '0;
    h.headers_present = 1;
    h.ether_type = ETHER_IPV4;
    h.ip_protocol = PROTO_UDP;
    h.dest_port = sb.port;
    {h.src_address, h.src_udp_port} = key;
    h.payload_len = LEN_W'(plen);
    return h;
  endfunction

  // beats after the first carry random header fields, which must be ignored
  task automatic send_packet(in_item_t head, logic [7:0] bytes [$], int nbeats,
                             bit with_first = 1, bit with_last = 1);
    in_item_t it;
    for (int i = 0; i < nbeats; i++) begin
      it = (i == 0) ? head : in_item_t'({$urandom, $urandom, $urandom, 16'($urandom)});
      it.data_byte = (i < bytes.size()) ? bytes[i] : 8'($urandom);
      it.first_beat = with_first && (i == 0);
      it.last_beat = with_last && (i == nbeats - 1);
      send_beat(it);
    end
    packets_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_port(logic [15:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i = 1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.port = value;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic random_packet();
    int unsigned r, n, plen;
    logic [7:0] bytes [$];
    in_item_t h;
    r = $urandom_range(0, 99);
    bytes = {};
    if (r < 10) begin
      h = in_item_t'({$urandom, $urandom, $urandom, 16'($urandom)});
      if ($urandom_range(0, 1)) h.dest_port = sb.port;
      send_packet(h, bytes, $urandom_range(1, 4));
    end else if (r < 14) begin
      send_packet('0, bytes, $urandom_range(1, 3), 0, 1);
    end else if (r < 17) begin
      // abandoned packet followed by a fresh one on a flow picked anew from the key pool
      send_packet(request_head(key_pool[$urandom_range(0, 7)], 8), bytes,
                  $urandom_range(1, 3), 1, 0);
      send_packet(request_head(key_pool[$urandom_range(0, 9)], 3), bytes, 3);
    end else if (r < 20) begin
      plen = $urandom_range(BUF_BYTES - 8, BUF_BYTES);
      send_packet(request_head(key_pool[$urandom_range(0, 9)], plen), bytes,
                  $urandom_range(1, 3));
    end else begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) bytes.push_back(8'($urandom));
      if (n >= 2 && $urandom_range(0, 99) < 40) begin
        bytes[n-2] = CHAR_Z;
        bytes[n-1] = CHAR_NL;
      end
      plen = n;
      if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, 14);
      send_packet(request_head(key_pool[$urandom_range(0, 9)], plen), bytes,
                  (n == 0) ? 1 : n);
    end
  endtask

  always begin
    if (hold_rx) begin
      repeat (400) begin
        @(negedge clk_i);
        pop = 0;
      end
      hold_rx = 0;
    end
    repeat ($urandom_range(0, 12)) begin
      @(negedge clk_i);
      pop = 0;
    end
    @(negedge clk_i);
    pop = 1;
    do @(posedge clk_i); while (empty || !rst_ni);
    sb.check_result(out_item_o);
  end

  initial begin
    logic [7:0] req [$];
    logic [15:0] ports [4];
    int unsigned quota;
    bit held;
    bit paused;
    sb = new();
    sb.clear_state();
    held = 0;
    paused = 0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, 16'($urandom)};
    key_pool[1] = '1;
    key_pool[2] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: filter misses, empty, short, request, extra and early beats
    req = {"G", "E", "T", "Z", CHAR_NL};
    send_packet(request_head(key_pool[0], 5), req, 5);
    send_packet(request_head(key_pool[1], 0), req, 1);
    send_packet(request_head(key_pool[2], 1), {8'hff}, 1);
    send_packet(request_head(key_pool[2], 1), {CHAR_Z}, 1);
    send_packet(request_head(key_pool[2], 2), {CHAR_NL, CHAR_NL}, 4);
    send_packet(request_head(key_pool[3], 4000), {CHAR_Z, CHAR_NL}, 2);
    send_packet(request_head(key_pool[2], BUF_BYTES), req, 2);
    send_packet('0, req, 2, 0, 1);
    begin
      in_item_t h;
      h = request_head(key_pool[0], 2);
      h.headers_present = 0;
      send_packet(h, req, 1);
      h = request_head(key_pool[0], 2);
      h.ether_type = 16'h86dd;
      send_packet(h, req, 1);
      h = request_head(key_pool[0], 2);
      h.ip_protocol = 8'd6;
      send_packet(h, req, 1);
    end
    write_port(16'd0);
    send_packet(request_head(key_pool[4], 2), {CHAR_Z, CHAR_NL}, 2);

    ports[0] = SERVER_PORT_RST;
    ports[1] = 16'hffff;
    ports[2] = 16'($urandom);
    ports[3] = SERVER_PORT_RST;
    for (int p = 0; p < 4; p++) begin
      write_port(ports[p]);
      quota = beats_sent + 380;
      while (beats_sent < quota) begin
        if (p == 1 && !held && beats_sent >= quota - 300) begin
          hold_rx = 1;
          held = 1;
        end
        random_packet();
        if (p == 2 && !paused && beats_sent >= quota - 200) begin
          wait_drained();
          paused = 1;
        end
      end
    end

    @(negedge clk_i);
    push = 0;
    wait_drained();
    $display("sent %0d beats in %0d packets, %0d results checked", beats_sent,
             packets_sent, sb.results);
    $display("verdicts: pass %0d, drop %0d, abort %0d, summary %0d", sb.verdict_cnt[0],
             sb.verdict_cnt[1], sb.verdict_cnt[2], sb.verdict_cnt[3]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ufra_pkg.sv
sv/ufra_front.sv
sv/ufra_back.sv
sv/udp_flow_request_accumulator.sv
test/udp_flow_request_accumulator_test.sv
